### design/srsc_pkg.sv
// Shared types, sizes and codes for the source rooted spanning cost block.
package srsc_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int MAX_EDGES = 4096;
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = EADDR_W + 1;
  localparam int SIZE_W    = NODE_W + 1;
  localparam int WEIGHT_W  = 32;
  localparam int COST_W    = 43;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;
  localparam logic [1:0] CMD_SOLVE = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_IMPOSSIBLE = 2'd1;
  localparam logic [1:0] STAT_ERROR      = 2'd2;

  localparam logic [2:0] OP_BEGIN = 3'd0;
  localparam logic [2:0] OP_MARK  = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_SOLVE = 3'd3;
  localparam logic [2:0] OP_ERR   = 3'd4;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [1:0]          command;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } srsc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [COST_W-1:0] total_cost;
  } srsc_out_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
  } srsc_op_t;

  typedef struct packed {
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
  } srsc_edge_t;

endpackage

### design/source_rooted_spanning_cost.sv
// Top level of the source rooted spanning cost block.
// Begin clears the marks over all nodes; mark and add each store one edge entry.
// Solve: set init over all nodes, then heap sort and union-find walks, then a root check
// of each unmarked node up to the node count; a load error yields the error status at once.
// Load items sustain one transfer per cycle through a two-entry op queue while the back end is idle.
// Reset: asynchronous active low; a mark clearing pass over all nodes follows before solving.
module source_rooted_spanning_cost_core import srsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  input  logic              push_i,
  output logic              full_o,
  input  srsc_in_t          in_item_i,
  output logic              empty_o,
  input  logic              pop_i,
  output srsc_out_t         out_item_o
);

  logic              op_valid, op_pop, res_valid;
  srsc_op_t          op;
  logic [NODE_W-1:0] node_count;

  srsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .in_item_i    (in_item_i),
    .node_count_o (node_count),
    .op_valid_o   (op_valid),
    .op_o         (op),
    .op_pop_i     (op_pop)
  );

  srsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count),
    .op_valid_i   (op_valid),
    .op_i         (op),
    .op_pop_o     (op_pop),
    .res_valid_o  (res_valid),
    .res_o        (out_item_o),
    .pop_i        (pop_i)
  );

  assign empty_o = !res_valid;

endmodule

### design/srsc_front.sv
// Front end: node count register, command classification and the op queue.
module srsc_front import srsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  input  logic              push_i,
  output logic              full_o,
  input  srsc_in_t          in_item_i,
  output logic [NODE_W-1:0] node_count_o,
  output logic              op_valid_o,
  output srsc_op_t          op_o,
  input  logic              op_pop_i
);

  logic [NODE_W-1:0] nc_q;
  srsc_op_t          fifo_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  srsc_op_t          cls;
  logic              do_push, do_pop;

  always_comb begin
    cls.a = in_item_i.node_a;
    cls.b = in_item_i.node_b;
    cls.w = in_item_i.weight;
    case (in_item_i.command)
      CMD_BEGIN: cls.op = OP_BEGIN;
      CMD_MARK: begin
        if (in_item_i.node_a == '0 || in_item_i.node_a > nc_q) cls.op = OP_ERR;
        else cls.op = OP_MARK;
      end
      CMD_ADD: begin
        if (in_item_i.node_a > nc_q || in_item_i.node_b > nc_q) cls.op = OP_ERR;
        else cls.op = OP_ADD;
      end
      default: cls.op = OP_SOLVE;
    endcase
  end

  assign full_o       = (cnt_q == 2'd2);
  assign op_valid_o   = (cnt_q != 2'd0);
  assign op_o         = fifo_q[rd_ptr_q];
  assign node_count_o = nc_q;
  assign do_push      = push_i && !full_o;
  assign do_pop       = op_pop_i && op_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q     <= NODE_W'(1);
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (cfg_we_i) nc_q <= cfg_wdata_i;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wr_ptr_q] <= cls;
  end

endmodule

### design/srsc_back.sv
// Back end: edge store, heap sort, union-find sequencer and result register.
module srsc_back import srsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NODE_W-1:0] node_count_i,
  input  logic              op_valid_i,
  input  srsc_op_t          op_i,
  output logic              op_pop_o,
  output logic              res_valid_o,
  output srsc_out_t         res_o,
  input  logic              pop_i
);

  localparam logic [4:0] ST_CLR     = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_INIT    = 5'd2;
  localparam logic [4:0] ST_B       = 5'd3;
  localparam logic [4:0] ST_SD_LD   = 5'd4;
  localparam logic [4:0] ST_SD      = 5'd5;
  localparam logic [4:0] ST_SD_CMP  = 5'd6;
  localparam logic [4:0] ST_X       = 5'd7;
  localparam logic [4:0] ST_X_LD    = 5'd8;
  localparam logic [4:0] ST_K       = 5'd9;
  localparam logic [4:0] ST_K_LD    = 5'd10;
  localparam logic [4:0] ST_RA      = 5'd11;
  localparam logic [4:0] ST_RB      = 5'd12;
  localparam logic [4:0] ST_SZ      = 5'd13;
  localparam logic [4:0] ST_J       = 5'd14;
  localparam logic [4:0] ST_FIN     = 5'd15;
  localparam logic [4:0] ST_R0      = 5'd16;
  localparam logic [4:0] ST_C       = 5'd17;
  localparam logic [4:0] ST_C_LD    = 5'd18;
  localparam logic [4:0] ST_RC      = 5'd19;
  localparam logic [4:0] ST_FIND_RD = 5'd20;
  localparam logic [4:0] ST_FIND_CK = 5'd21;
  localparam logic [4:0] ST_EMIT    = 5'd22;

  srsc_edge_t        edge_mem [MAX_EDGES];
  logic [NODE_W-1:0] par_mem  [MAX_NODES];
  logic [SIZE_W-1:0] size_mem [MAX_NODES];
  logic              mark_mem [MAX_NODES];

  logic [4:0]          state_q, ret_q;
  logic [ECNT_W-1:0]   ecnt_q, bi_q, ei_q, r_q, hsz_q, ki_q;
  logic                err_q, build_q;
  logic [NODE_W-1:0]   k_q, fx_q, root_q, r1_q, r2_q, root0_q, acc_q;
  logic [NODE_W:0]     ci_q;
  logic [COST_W-1:0]   cost_q;
  srsc_edge_t          cur_q, eb_q, rd0_q, rd1_q;
  logic [NODE_W-1:0]   p_rd_q;
  logic [SIZE_W-1:0]   s1_q, s2_q;
  logic                m_rd_q;
  srsc_out_t           res_q, out_q;
  logic                out_valid_q;

  logic [EADDR_W-1:0]  ra0, ra1, e_wa;
  logic                e_we;
  srsc_edge_t          e_wd, dc;
  logic [ECNT_W:0]     child, child_p1, cidx;
  logic                pick1, sift_stop;
  logic [COST_W:0]     cost_sum;
  logic [SIZE_W-1:0]   s_sum;

  assign child    = {r_q, 1'b1};
  assign child_p1 = child + 1'b1;
  assign pick1    = (child_p1 < {1'b0, hsz_q}) && (rd1_q.w > rd0_q.w);
  assign dc       = pick1 ? rd1_q : rd0_q;
  assign cidx     = pick1 ? child_p1 : child;
  assign sift_stop = (dc.w <= cur_q.w);
  assign cost_sum = {1'b0, cost_q} + (COST_W + 1)'(eb_q.w);
  assign s_sum    = s1_q + s2_q;
  assign op_pop_o = (state_q == ST_IDLE) && op_valid_i;

  always_comb begin
    ra0 = '0;
    ra1 = '0;
    case (state_q)
      ST_B:  ra0 = EADDR_W'(bi_q - 1'b1);
      ST_SD: begin
        ra0 = child[EADDR_W-1:0];
        ra1 = child_p1[EADDR_W-1:0];
      end
      ST_X:  ra1 = ei_q[EADDR_W-1:0];
      ST_K:  ra0 = ki_q[EADDR_W-1:0];
      default: ;
    endcase
  end

  always_comb begin
    e_we = 1'b0;
    e_wa = r_q[EADDR_W-1:0];
    e_wd = cur_q;
    case (state_q)
      ST_IDLE: begin
        e_wa   = ecnt_q[EADDR_W-1:0];
        e_wd.a = op_i.a;
        e_wd.b = (op_i.op == OP_MARK) ? '0 : op_i.b;
        e_wd.w = (op_i.op == OP_MARK) ? '0 : op_i.w;
        e_we   = op_valid_i && !err_q && (ecnt_q < ECNT_W'(MAX_EDGES)) &&
                 (op_i.op == OP_MARK || op_i.op == OP_ADD);
      end
      ST_SD: e_we = (child >= {1'b0, hsz_q});
      ST_SD_CMP: begin
        e_we = 1'b1;
        e_wd = sift_stop ? cur_q : dc;
      end
      ST_X_LD: begin
        e_we = 1'b1;
        e_wa = ei_q[EADDR_W-1:0];
        e_wd = rd0_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd0_q  <= edge_mem[ra0];
    rd1_q  <= edge_mem[ra1];
    if (e_we) edge_mem[e_wa] <= e_wd;
    p_rd_q <= par_mem[fx_q];
    s1_q   <= size_mem[r1_q];
    s2_q   <= size_mem[r2_q];
    m_rd_q <= mark_mem[ci_q[NODE_W-1:0]];
    if (state_q == ST_INIT) begin
      par_mem[k_q]  <= k_q;
      size_mem[k_q] <= SIZE_W'(1);
    end else if (state_q == ST_J) begin
      if (s2_q > s1_q) begin
        par_mem[r1_q]  <= r2_q;
        size_mem[r2_q] <= s_sum;
      end else begin
        par_mem[r2_q]  <= r1_q;
        size_mem[r1_q] <= s_sum;
      end
    end
    if (state_q == ST_CLR) mark_mem[k_q] <= 1'b0;
    else if (op_pop_o && op_i.op == OP_MARK) mark_mem[op_i.a] <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      k_q         <= '0;
      ecnt_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          k_q <= k_q + 1'b1;
          if (k_q == {NODE_W{1'b1}}) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (op_valid_i) begin
            case (op_i.op)
              OP_BEGIN: begin
                ecnt_q  <= '0;
                err_q   <= 1'b0;
                k_q     <= '0;
                state_q <= ST_CLR;
              end
              OP_MARK, OP_ADD: begin
                if (ecnt_q >= ECNT_W'(MAX_EDGES)) err_q <= 1'b1;
                else if (!err_q) ecnt_q <= ecnt_q + 1'b1;
              end
              OP_SOLVE: begin
                if (err_q) begin
                  res_q.status     <= STAT_ERROR;
                  res_q.total_cost <= '0;
                  state_q          <= ST_EMIT;
                end else begin
                  k_q     <= '0;
                  state_q <= ST_INIT;
                end
              end
              default: err_q <= 1'b1;
            endcase
          end
        end
        ST_INIT: begin
          k_q    <= k_q + 1'b1;
          ki_q   <= '0;
          acc_q  <= '0;
          cost_q <= '0;
          if (k_q == {NODE_W{1'b1}}) begin
            if (ecnt_q < ECNT_W'(2)) state_q <= ST_K;
            else begin
              bi_q    <= ecnt_q >> 1;
              build_q <= 1'b1;
              state_q <= ST_B;
            end
          end
        end
        ST_B: begin
          if (bi_q == '0) begin
            build_q <= 1'b0;
            ei_q    <= ecnt_q - 1'b1;
            state_q <= ST_X;
          end else begin
            r_q     <= bi_q - 1'b1;
            hsz_q   <= ecnt_q;
            state_q <= ST_SD_LD;
          end
        end
        ST_SD_LD: begin
          cur_q   <= rd0_q;
          state_q <= ST_SD;
        end
        ST_SD: begin
          if (child >= {1'b0, hsz_q}) begin
            if (build_q) begin
              bi_q <= bi_q - 1'b1;
              state_q <= ST_B;
            end else begin
              ei_q <= ei_q - 1'b1;
              state_q <= ST_X;
            end
          end else state_q <= ST_SD_CMP;
        end
        ST_SD_CMP: begin
          if (sift_stop) begin
            if (build_q) begin
              bi_q <= bi_q - 1'b1;
              state_q <= ST_B;
            end else begin
              ei_q <= ei_q - 1'b1;
              state_q <= ST_X;
            end
          end else begin
            r_q     <= cidx[ECNT_W-1:0];
            state_q <= ST_SD;
          end
        end
        ST_X: begin
          if (ei_q == '0) state_q <= ST_K;
          else state_q <= ST_X_LD;
        end
        ST_X_LD: begin
          cur_q   <= rd1_q;
          r_q     <= '0;
          hsz_q   <= ei_q;
          state_q <= ST_SD;
        end
        ST_K: begin
          if (ki_q >= ecnt_q || acc_q >= node_count_i) state_q <= ST_FIN;
          else state_q <= ST_K_LD;
        end
        ST_K_LD: begin
          eb_q    <= rd0_q;
          fx_q    <= rd0_q.a;
          ret_q   <= ST_RA;
          state_q <= ST_FIND_RD;
        end
        ST_RA: begin
          r1_q    <= root_q;
          fx_q    <= eb_q.b;
          ret_q   <= ST_RB;
          state_q <= ST_FIND_RD;
        end
        ST_RB: begin
          if (root_q == r1_q) begin
            ki_q    <= ki_q + 1'b1;
            state_q <= ST_K;
          end else begin
            r2_q    <= root_q;
            cost_q  <= cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
            state_q <= ST_SZ;
          end
        end
        ST_SZ: state_q <= ST_J;
        ST_J: begin
          acc_q   <= acc_q + 1'b1;
          ki_q    <= ki_q + 1'b1;
          state_q <= ST_K;
        end
        ST_FIN: begin
          fx_q    <= '0;
          ret_q   <= ST_R0;
          state_q <= ST_FIND_RD;
        end
        ST_R0: begin
          root0_q <= root_q;
          ci_q    <= (NODE_W + 1)'(1);
          state_q <= ST_C;
        end
        ST_C: begin
          if (ci_q > {1'b0, node_count_i}) begin
            res_q.status     <= STAT_OK;
            res_q.total_cost <= cost_q;
            state_q          <= ST_EMIT;
          end else state_q <= ST_C_LD;
        end
        ST_C_LD: begin
          if (m_rd_q) begin
            ci_q    <= ci_q + 1'b1;
            state_q <= ST_C;
          end else begin
            fx_q    <= ci_q[NODE_W-1:0];
            ret_q   <= ST_RC;
            state_q <= ST_FIND_RD;
          end
        end
        ST_RC: begin
          if (root_q != root0_q) begin
            res_q.status     <= STAT_IMPOSSIBLE;
            res_q.total_cost <= '0;
            state_q          <= ST_EMIT;
          end else begin
            ci_q    <= ci_q + 1'b1;
            state_q <= ST_C;
          end
        end
        ST_FIND_RD: state_q <= ST_FIND_CK;
        ST_FIND_CK: begin
          if (p_rd_q == fx_q) begin
            root_q  <= fx_q;
            state_q <= ret_q;
          end else begin
            fx_q    <= p_rd_q;
            state_q <= ST_FIND_RD;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // The edge count never passes the store depth.
  a_ecnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= ECNT_W'(MAX_EDGES)) else $error("edge count beyond store depth");

  // A finished result is placed in the free output register on the next cycle.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_valid_q) |=> out_valid_q)
    else $error("result not delivered to output register");

  // A sift position always lies inside the current heap.
  a_sift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SD) |-> (r_q < hsz_q)) else $error("sift position outside heap");

  // Only a connected answer carries a cost.
  a_cost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STAT_OK) |-> (out_q.total_cost == '0))
    else $error("cost on a failed result");

endmodule

### tb/testbench.sv
// Self-checking testbench for the source rooted spanning cost core.
`timescale 1ns / 1ps

module testbench;
  import srsc_pkg::*;

  localparam int CLEAR_WAIT = 3000;
  localparam int HOLD_LEN   = 12000;
  localparam longint LIMIT  = 20000000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [NODE_W-1:0] cfg_wdata_i;
  logic              push_i;
  logic              full_o;
  srsc_in_t          in_item_i;
  logic              empty_o;
  logic              pop_i;
  srsc_out_t         out_item_o;

  source_rooted_spanning_cost_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

  // Predictor state: graph store, union-find forest and the node count.
  int                  nodes_cfg;
  logic [NODE_W-1:0]   edge_a [MAX_EDGES];
  logic [NODE_W-1:0]   edge_b [MAX_EDGES];
  logic [WEIGHT_W-1:0] edge_w [MAX_EDGES];
  int                  edges_held;
  bit                  load_error;
  bit                  is_source [MAX_NODES];
  int                  uplink [MAX_NODES];
  int                  tree_size [MAX_NODES];

  srsc_out_t expected_answers[$];
  int        errors;
  int        items_sent;
  bit        calm;
  bit        hold_rx;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void forest_init();
    for (int i = 0; i < MAX_NODES; i++) begin
      uplink[i] = i;
      tree_size[i] = 1;
    end
  endfunction

  function automatic void clear_graph();
    forest_init();
    for (int i = 0; i < MAX_NODES; i++) is_source[i] = 1'b0;
    edges_held = 0;
    load_error = 1'b0;
  endfunction

  function automatic int find_root(int x);
    x = x % MAX_NODES;
    while (uplink[x] != x) begin
      uplink[x] = uplink[uplink[x]];
      x = uplink[x];
    end
    return x;
  endfunction

  function automatic void swap_edges(int i, int j);
    logic [NODE_W-1:0]   ta;
    logic [NODE_W-1:0]   tb;
    logic [WEIGHT_W-1:0] tw;
    ta = edge_a[i]; tb = edge_b[i]; tw = edge_w[i];
    edge_a[i] = edge_a[j]; edge_b[i] = edge_b[j]; edge_w[i] = edge_w[j];
    edge_a[j] = ta; edge_b[j] = tb; edge_w[j] = tw;
  endfunction

  function automatic void sift_down(int r, int n);
    int child;
    forever begin
      child = 2 * r + 1;
      if (child >= n) return;
      if (child + 1 < n && edge_w[child+1] > edge_w[child]) child++;
      if (edge_w[child] <= edge_w[r]) return;
      swap_edges(r, child);
      r = child;
    end
  endfunction

  function automatic void heap_sort(int n);
    if (n < 2) return;
    for (int i = n / 2; i > 0; i--) sift_down(i - 1, n);
    for (int i = n - 1; i > 0; i--) begin
      swap_edges(0, i);
      sift_down(0, i);
    end
  endfunction

  function automatic bit node_fits(int v);
    return v <= nodes_cfg && v < MAX_NODES;
  endfunction

  function automatic void store_edge(int a, int b, logic [WEIGHT_W-1:0] w);
    if (edges_held >= MAX_EDGES) begin
      load_error = 1'b1;
      return;
    end
    edge_a[edges_held] = NODE_W'(a);
    edge_b[edges_held] = NODE_W'(b);
    edge_w[edges_held] = w;
    edges_held++;
  endfunction

  // Applies one accepted item; a solve yields the expected answer.
  function automatic void spanning_answer(srsc_in_t it, output bit has,
                                          output srsc_out_t ans);
    logic [63:0] acc;
    int accepted, r1, r2, r0, last;
    has = 1'b0;
    ans = '0;
    case (it.command)
      CMD_BEGIN: clear_graph();
      CMD_MARK: begin
        if (it.node_a == 0 || !node_fits(it.node_a)) load_error = 1'b1;
        else begin
          is_source[it.node_a] = 1'b1;
          store_edge(it.node_a, 0, '0);
        end
      end
      CMD_ADD: begin
        if (!node_fits(it.node_a) || !node_fits(it.node_b)) load_error = 1'b1;
        else store_edge(it.node_a, it.node_b, it.weight);
      end
      default: begin
        has = 1'b1;
        if (load_error) begin
          ans.status = STAT_ERROR;
          return;
        end
        forest_init();
        heap_sort(edges_held);
        acc = '0;
        accepted = 0;
        for (int i = 0; i < edges_held && accepted < nodes_cfg; i++) begin
          r1 = find_root(edge_a[i]);
          r2 = find_root(edge_b[i]);
          if (r1 != r2) begin
            acc += edge_w[i];
            if (acc > COST_MAX) acc = COST_MAX;
            if (tree_size[r2] > tree_size[r1]) begin
              r0 = r1; r1 = r2; r2 = r0;
            end
            uplink[r2] = r1;
            tree_size[r1] += tree_size[r2];
            accepted++;
          end
        end
        last = (nodes_cfg > MAX_NODES - 1) ? MAX_NODES - 1 : nodes_cfg;
        r0 = find_root(0);
        for (int i = 1; i <= last; i++) begin
          if (!is_source[i] && find_root(i) != r0) begin
            ans.status = STAT_IMPOSSIBLE;
            return;
          end
        end
        ans.status = STAT_OK;
        ans.total_cost = acc[COST_W-1:0];
      end
    endcase
  endfunction

  task automatic send_item(srsc_in_t it, bit typed = 1'b0, srsc_out_t want = '0);
    bit        has;
    srsc_out_t got;
    if (!calm && $urandom_range(0, 99) < 12) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full_o);
    items_sent++;
    spanning_answer(it, has, got);
    if (has) expected_answers.insert(expected_answers.size(), typed ? want : got);
  endtask

  function automatic srsc_in_t make_item(logic [1:0] cmd, int a, int b,
                                         logic [WEIGHT_W-1:0] w);
    srsc_in_t it;
    it.command = cmd;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    it.weight = w;
    return it;
  endfunction

  // The sender pauses until every answer is back and the block is quiet.
  task automatic wait_drained();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (CLEAR_WAIT) @(posedge clk_i);
  endtask

  task automatic write_nodes(int v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= NODE_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nodes_cfg = v;
  endtask

  function automatic int pick_node(int nc, bit with_root);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, MAX_NODES - 1);
    return $urandom_range(with_root ? 0 : 1, nc);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // One graph: optional clear, a few sources, a batch of edges, then a solve, sometimes repeated.
  task automatic random_graph(int nc);
    int a, m;
    if ($urandom_range(0, 7) != 0) send_item(make_item(CMD_BEGIN, 0, 0, $urandom));
    repeat ($urandom_range(0, 3))
      send_item(make_item(CMD_MARK, pick_node(nc, 1'b0), $urandom_range(0, 1023),
                          $urandom));
    m = $urandom_range(1, (nc < 24) ? nc + 3 : 24);
    repeat (m) begin
      a = pick_node(nc, 1'b1);
      if ($urandom_range(0, 1) == 0 && a > 0 && a <= nc)
        send_item(make_item(CMD_ADD, a, a - 1, pick_weight()));
      else
        send_item(make_item(CMD_ADD, a, pick_node(nc, 1'b1), pick_weight()));
    end
    send_item(make_item(CMD_SOLVE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom));
    if ($urandom_range(0, 3) == 0) send_item(make_item(CMD_SOLVE, 0, 0, 0));
  endtask

  typedef struct {
    srsc_in_t  it;
    bit        typed;
    srsc_out_t want;
  } stim_row_t;

  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected answer status=%0d cost=%0d", $time,
                   out_item_o.status, out_item_o.total_cost);
          errors++;
        end else begin
          if (out_item_o.status !== expected_answers[0].status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     expected_answers[0].status, out_item_o.status);
            errors++;
          end
          if (out_item_o.total_cost !== expected_answers[0].total_cost) begin
            $display("%0t: total_cost expected %0d actual %0d", $time,
                     expected_answers[0].total_cost, out_item_o.total_cost);
            errors++;
          end
          void'(expected_answers.pop_front());
        end
      end
      // A hold request starts one long stretch of refusing results.
      if (hold_rx && !hold_seen) begin
        hold_left = HOLD_LEN;
        hold_seen = 1'b1;
      end
      if (!hold_rx) hold_seen = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    srsc_out_t ok0, imp, err, okmax;
    int counts[] = '{1023, 5, 1, 12, 60, 3, 1023, 2, 8};
    int phase_end;
    items_sent = 0;
    calm = 1'b0;
    hold_rx = 1'b0;
    nodes_cfg = 1;
    clear_graph();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    push_i <= 1'b0;
    in_item_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ok0 = '{status: STAT_OK, total_cost: '0};
    imp = '{status: STAT_IMPOSSIBLE, total_cost: '0};
    err = '{status: STAT_ERROR, total_cost: '0};
    okmax = '{status: STAT_OK, total_cost: 43'hFFFF_FFFF};
    // Node count is one after reset.
    rows = '{
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, imp},
      '{make_item(CMD_MARK, 1, 0, 0), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, ok0},
      '{make_item(CMD_ADD, 1, 0, 32'hFFFF_FFFF), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 0, ok0},
      '{make_item(CMD_BEGIN, 1023, 1023, 32'hFFFF_FFFF), 0, ok0},
      '{make_item(CMD_ADD, 0, 1, 32'hFFFF_FFFF), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, okmax},
      '{make_item(CMD_ADD, 0, 1, 0), 0, ok0},
      '{make_item(CMD_SOLVE, 1023, 1023, 32'hFFFF_FFFF), 0, ok0},
      '{make_item(CMD_MARK, 0, 0, 0), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, err},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, err},
      '{make_item(CMD_BEGIN, 0, 0, 0), 0, ok0},
      '{make_item(CMD_ADD, 2, 1, 5), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, err},
      '{make_item(CMD_BEGIN, 0, 0, 0), 0, ok0},
      '{make_item(CMD_MARK, 1023, 0, 0), 0, ok0},
      '{make_item(CMD_ADD, 1023, 0, 1), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, err},
      '{make_item(CMD_BEGIN, 0, 0, 0), 0, ok0},
      '{make_item(CMD_MARK, 1, 0, 0), 0, ok0},
      '{make_item(CMD_MARK, 1, 0, 0), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, ok0},
      '{make_item(CMD_BEGIN, 0, 0, 0), 0, ok0},
      '{make_item(CMD_ADD, 1, 1, 7), 0, ok0},
      '{make_item(CMD_SOLVE, 0, 0, 0), 1, imp}
    };
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
    wait_drained();

    foreach (counts[p]) begin
      write_nodes(counts[p]);
      phase_end = items_sent + 65;
      while (items_sent < phase_end) begin
        calm = (items_sent >= 300 && items_sent < 450);
        random_graph(counts[p]);
      end
      calm = 1'b0;
      wait_drained();
    end

    // Receiver holds off while solves keep coming, so the block backs up.
    write_nodes(3);
    hold_rx = 1'b1;
    repeat (8) begin
      send_item(make_item(CMD_BEGIN, 0, 0, 0));
      send_item(make_item(CMD_MARK, 2, 0, 0));
      send_item(make_item(CMD_ADD, 1, 3, $urandom_range(0, 9)));
      send_item(make_item(CMD_ADD, 3, 2, $urandom_range(0, 9)));
      send_item(make_item(CMD_SOLVE, 0, 0, 0));
    end
    hold_rx = 1'b0;
    wait_drained();

    // Shrink the node count after loading; stored edges stay in use.
    write_nodes(12);
    send_item(make_item(CMD_BEGIN, 0, 0, 0));
    for (int i = 1; i <= 12; i++)
      send_item(make_item(CMD_ADD, i, i - 1, $urandom_range(0, 50)));
    send_item(make_item(CMD_ADD, 12, 7, 0));
    wait_drained();
    write_nodes(5);
    send_item(make_item(CMD_SOLVE, 0, 0, 0));
    wait_drained();

    // Largest node count with a single source at the top node.
    write_nodes(1023);
    send_item(make_item(CMD_BEGIN, 0, 0, 0));
    send_item(make_item(CMD_MARK, 1023, 0, 0));
    send_item(make_item(CMD_SOLVE, 0, 0, 0));
    wait_drained();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
